[src/b2h_pkg.sv]
// shared types and constants of the binary to hex record encoder
package b2h_pkg;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned QUEUE_DEPTH = 2;

  // input opcodes
  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_SIZE   = 2'd1;
  localparam logic [1:0] CFG_LENGTH = 2'd2;
  localparam logic [1:0] CFG_OFFSET = 2'd3;

  // format register codes
  localparam logic [1:0] CFG_FMT_SREC = 2'd0;
  localparam logic [1:0] CFG_FMT_IHEX = 2'd1;
  localparam logic [1:0] CFG_FMT_TEK  = 2'd2;

  localparam logic [7:0] REC_SIZE_RST  = 8'd32;
  localparam logic [7:0] SREC_MAX_SIZE = 8'd251;

  typedef enum logic [1:0] {
    FMT_SREC,
    FMT_IHEX,
    FMT_TEK
  } rec_fmt_e;

  typedef struct packed {
    logic [1:0]        fmt;
    logic [7:0]        size;
    logic [ADDR_W-1:0] img_len;
    logic [ADDR_W-1:0] offset;
  } cfg_t;

  // one classified item, handed from front to back
  typedef struct packed {
    rec_fmt_e        fmt;
    logic            is_finish;
    logic            has_hdr;
    logic            has_close;
    logic            drop_nl;
    logic [3:0][7:0] hdr;
    logic [7:0]      data;
    logic [7:0]      chk;
    logic [4:0][7:0] term;
  } enc_word_t;

  // unknown format codes behave as s-records
  function automatic rec_fmt_e fmt_decode(logic [1:0] code);
    rec_fmt_e f;
    case (code)
      CFG_FMT_IHEX: f = FMT_IHEX;
      CFG_FMT_TEK:  f = FMT_TEK;
      default:      f = FMT_SREC;
    endcase
    return f;
  endfunction

endpackage

[src/b2h_front.sv]
// front end: accepts words, tracks record state, builds record descriptors
module b2h_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b2h_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [7:0]         data_byte_i,
  input  logic               q_full_i,
  output logic               push_o,
  output b2h_pkg::enc_word_t word_o
);
  import b2h_pkg::*;

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]        pos_q, pos_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        sum_q, sum_d;

  rec_fmt_e          fmt;
  logic              accept, is_fin, skip, opening, close_now;
  logic [7:0]        eff, len, len_cur, pos_next;
  logic [ADDR_W-1:0] remain, srec_addr;
  logic [7:0]        hdr_sum, data_add, base, new_sum, chk_src, s8_sum;
  logic [3:0][7:0]   hdr;
  logic [4:0][7:0]   term;

  function automatic logic [7:0] nib_sum(logic [7:0] x);
    return {4'b0, x[7:4]} + {4'b0, x[3:0]};
  endfunction

  // classify the word and work out this record's bytes and sums
  always_comb begin
    fmt       = fmt_decode(cfg_i.fmt);
    accept    = in_valid_i && !q_full_i;
    is_fin    = (opcode_i == OP_FINISH);
    skip      = !is_fin && (addr_q >= cfg_i.img_len);
    opening   = (pos_q == 8'd0);

    eff = (cfg_i.size == 8'd0) ? 8'd1 : cfg_i.size;
    if (fmt == FMT_SREC && eff > SREC_MAX_SIZE) begin
      eff = SREC_MAX_SIZE;
    end
    remain    = cfg_i.img_len - addr_q;
    len       = (remain < {16'b0, eff}) ? remain[7:0] : eff;
    srec_addr = addr_q + cfg_i.offset;

    case (fmt)
      FMT_IHEX: begin
        hdr[0] = len;
        hdr[1] = addr_q[15:8];
        hdr[2] = addr_q[7:0];
        hdr[3] = 8'h00;
      end
      FMT_TEK: begin
        hdr[0] = addr_q[15:8];
        hdr[1] = addr_q[7:0];
        hdr[2] = len;
        hdr[3] = nib_sum(addr_q[15:8]) + nib_sum(addr_q[7:0]) + nib_sum(len);
      end
      default: begin
        hdr[0] = len + 8'd4;
        hdr[1] = srec_addr[23:16];
        hdr[2] = srec_addr[15:8];
        hdr[3] = srec_addr[7:0];
      end
    endcase

    // tekhex restarts the data sum after the header
    hdr_sum  = (fmt == FMT_TEK) ? 8'd0 : (hdr[0] + hdr[1] + hdr[2] + hdr[3]);
    data_add = (fmt == FMT_TEK) ? nib_sum(data_byte_i) : data_byte_i;
    base     = opening ? hdr_sum : sum_q;
    new_sum  = base + data_add;
    pos_next = (opening ? 8'd0 : pos_q) + 8'd1;
    len_cur  = opening ? len : len_q;
    close_now = (pos_next >= len_cur);

    chk_src = is_fin ? sum_q : new_sum;
    s8_sum  = 8'd4 + cfg_i.offset[23:16] + cfg_i.offset[15:8] + cfg_i.offset[7:0];

    case (fmt)
      FMT_IHEX: begin
        word_o.chk = 8'd0 - chk_src;
        term = {8'hFF, 8'h01, 8'h00, 8'h00, 8'h00};
      end
      FMT_TEK: begin
        word_o.chk = chk_src;
        term = '0;
      end
      default: begin
        word_o.chk = ~chk_src;
        term = {~s8_sum, cfg_i.offset[7:0], cfg_i.offset[15:8], cfg_i.offset[23:16], 8'h04};
      end
    endcase

    word_o.fmt       = fmt;
    word_o.is_finish = is_fin;
    word_o.has_hdr   = !is_fin && opening;
    word_o.has_close = is_fin ? !opening : close_now;
    word_o.drop_nl   = is_fin && (fmt == FMT_SREC) && !opening;
    word_o.hdr       = hdr;
    word_o.data      = data_byte_i;
    word_o.term      = term;

    push_o     = accept && !skip;
    in_stall_o = q_full_i;

    // record state update
    addr_d = addr_q;
    pos_d  = pos_q;
    len_d  = len_q;
    sum_d  = sum_q;
    if (accept) begin
      if (is_fin) begin
        addr_d = '0;
        pos_d  = '0;
        len_d  = '0;
        sum_d  = '0;
      end else if (!skip) begin
        addr_d = addr_q + ADDR_W'(1);
        pos_d  = close_now ? 8'd0 : pos_next;
        len_d  = len_cur;
        sum_d  = new_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      pos_q  <= '0;
      len_q  <= '0;
      sum_q  <= '0;
    end else begin
      addr_q <= addr_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      sum_q  <= sum_d;
    end
  end

  // an open record never holds its full length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != 8'd0) |-> (pos_q < len_q))
    else $error("open record position reached its length");

endmodule

[src/b2h_queue.sv]
// short descriptor queue between front and back
module b2h_queue #(
  parameter int unsigned Depth = b2h_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b2h_pkg::enc_word_t word_i,
  input  logic               pop_i,
  output b2h_pkg::enc_word_t word_o,
  output logic               full_o,
  output logic               empty_o
);
  import b2h_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  enc_word_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // pointer and fill count
  always_comb begin
    full_o   = (cnt_q == CntW'(Depth));
    empty_o  = (cnt_q == '0);
    word_o   = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

[src/b2h_back.sv]
// back end: walks a descriptor and sends its characters one by one
module b2h_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b2h_pkg::enc_word_t word_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         char_out_o,
  output logic               last_char_o
);
  import b2h_pkg::*;

  typedef enum logic [1:0] {
    SEG_HDR,
    SEG_DATA,
    SEG_CLOSE,
    SEG_TERM
  } seg_e;

  localparam logic [6:0] CH_NL    = 7'h0A;
  localparam logic [6:0] CH_S     = 7'h53;
  localparam logic [6:0] CH_TWO   = 7'h32;
  localparam logic [6:0] CH_EIGHT = 7'h38;
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_SLASH = 7'h2F;

  seg_e       seg_q, seg_d, cur_seg, first_seg, nxt_seg;
  logic [3:0] pos_q, pos_d, cur_pos, pre_len, seg_len, k;
  logic       started_q, started_d;
  logic       out_valid_q;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load, active, emit, seg_end;
  logic [7:0] tbyte;

  function automatic logic [6:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? (7'h30 + {3'b0, n}) : (7'h37 + {3'b0, n});
  endfunction

  function automatic logic [6:0] nib_char(logic [7:0] b, logic lo);
    return hex_char(lo ? b[3:0] : b[7:4]);
  endfunction

  // segment sequencing and character selection
  always_comb begin
    load   = !out_valid_q || !out_stall_i;
    active = !empty_i;
    emit   = load && active;

    if (word_i.has_hdr) begin
      first_seg = SEG_HDR;
    end else if (!word_i.is_finish) begin
      first_seg = SEG_DATA;
    end else if (word_i.has_close) begin
      first_seg = SEG_CLOSE;
    end else begin
      first_seg = SEG_TERM;
    end
    cur_seg = started_q ? seg_q : first_seg;
    cur_pos = started_q ? pos_q : 4'd0;

    pre_len = (word_i.fmt == FMT_SREC) ? 4'd2 : 4'd1;
    k       = cur_pos - pre_len;

    case (cur_seg)
      SEG_HDR:   seg_len = pre_len + 4'd8;
      SEG_DATA:  seg_len = 4'd2;
      SEG_CLOSE: seg_len = 4'd3;
      default: begin
        if (word_i.fmt == FMT_TEK) begin
          seg_len = 4'd10;
        end else if (word_i.fmt == FMT_IHEX || word_i.drop_nl) begin
          seg_len = 4'd12;
        end else begin
          seg_len = 4'd13;
        end
      end
    endcase
    seg_end = (cur_pos == seg_len - 4'd1);

    case (cur_seg)
      SEG_HDR:   nxt_seg = SEG_DATA;
      SEG_DATA:  nxt_seg = SEG_CLOSE;
      default:   nxt_seg = SEG_TERM;
    endcase

    last_d = seg_end && ((cur_seg == SEG_TERM) ||
                         (cur_seg == SEG_CLOSE && !word_i.is_finish) ||
                         (cur_seg == SEG_DATA && !word_i.has_close));

    case (k[3:1])
      3'd0:    tbyte = word_i.term[0];
      3'd1:    tbyte = word_i.term[1];
      3'd2:    tbyte = word_i.term[2];
      3'd3:    tbyte = word_i.term[3];
      3'd4:    tbyte = word_i.term[4];
      default: tbyte = 8'h00;
    endcase

    case (cur_seg)
      SEG_HDR: begin
        if (cur_pos < pre_len) begin
          if (word_i.fmt == FMT_SREC) begin
            char_d = (cur_pos == 4'd0) ? CH_S : CH_TWO;
          end else begin
            char_d = (word_i.fmt == FMT_IHEX) ? CH_COLON : CH_SLASH;
          end
        end else begin
          char_d = nib_char(word_i.hdr[k[2:1]], k[0]);
        end
      end
      SEG_DATA:  char_d = nib_char(word_i.data, cur_pos[0]);
      SEG_CLOSE: char_d = (cur_pos == 4'd2) ? CH_NL : nib_char(word_i.chk, cur_pos[0]);
      default: begin
        if (cur_pos < pre_len) begin
          if (word_i.fmt == FMT_SREC) begin
            char_d = (cur_pos == 4'd0) ? CH_S : CH_EIGHT;
          end else begin
            char_d = (word_i.fmt == FMT_IHEX) ? CH_COLON : CH_SLASH;
          end
        end else if (k >= ((word_i.fmt == FMT_TEK) ? 4'd8 : 4'd10)) begin
          char_d = CH_NL;
        end else begin
          char_d = nib_char(tbyte, k[0]);
        end
      end
    endcase

    pop_o     = emit && last_d;
    started_d = started_q;
    seg_d     = seg_q;
    pos_d     = pos_q;
    if (emit) begin
      started_d = !last_d;
      if (seg_end) begin
        seg_d = nxt_seg;
        pos_d = 4'd0;
      end else begin
        seg_d = cur_seg;
        pos_d = cur_pos + 4'd1;
      end
    end
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      seg_q       <= SEG_HDR;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      started_q <= started_d;
      seg_q     <= seg_d;
      pos_q     <= pos_d;
      if (load) begin
        out_valid_q <= active;
      end
      if (emit) begin
        char_q <= char_d;
        last_q <= last_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_char_o = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) started_q |-> !empty_i)
    else $error("descriptor left the queue mid record");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cur_seg == SEG_TERM) |-> word_i.is_finish)
    else $error("termination record on a data word");

endmodule

[src/binary_to_hex_record_encoder_core.sv]
// top level: config registers, front end, descriptor queue and character back end
//
//   channel  | direction | handshake              | payload
//   in       | input     | in_valid_i/in_stall_o  | opcode_i, data_byte_i
//   out      | output    | out_valid_o/out_stall_i| char_out_o, last_char_o
//   cfg      | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// the front takes one word a cycle while the queue has room; the back sends
// one character a cycle while out_stall_i is low: a plain data byte gives
// two characters, a word with a header and checksum up to fifteen.
// a word is held in the queue, then its first character in the output register.
// reset clears record state, queue and config to their defaults; no clearing pass.
// out_stall_i holds the output register; the queue then fills and raises in_stall_o.
module binary_to_hex_record_encoder_core #(
  parameter int unsigned QueueDepth = b2h_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [b2h_pkg::ADDR_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [7:0]                  data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [6:0]                  char_out_o,
  output logic                        last_char_o
);
  import b2h_pkg::*;

  cfg_t      cfg_q;
  enc_word_t push_word, head_word;
  logic      push, pop, q_full, q_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt     <= CFG_FMT_SREC;
      cfg_q.size    <= REC_SIZE_RST;
      cfg_q.img_len <= '0;
      cfg_q.offset  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FORMAT: cfg_q.fmt     <= cfg_data_i[1:0];
        CFG_SIZE:   cfg_q.size    <= cfg_data_i[7:0];
        CFG_LENGTH: cfg_q.img_len <= cfg_data_i;
        CFG_OFFSET: cfg_q.offset  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  b2h_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .word_o      (push_word)
  );

  b2h_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .pop_i   (pop),
    .word_o  (head_word),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b2h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (head_word),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o)
  );

endmodule

[dv/tb_binary_to_hex_record_encoder_core.sv]
// testbench for the binary to hex record encoder: directed table, random phases, char checks
module tb_binary_to_hex_record_encoder_core;
  import b2h_pkg::*;

  localparam int unsigned MAX_CHARS    = 15;
  localparam int unsigned ITEM_TARGET  = 380;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned WATCHDOG_MAX = 1500;
  // format code with no meaning of its own, decoded as s-record
  localparam logic [1:0] FMT_CODE_SPARE = 2'd3;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_res_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [23:0] val;
    logic        op;
    logic [7:0]  data_v;
    logic        typed;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_index_i;
  logic [ADDR_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [7:0]           data_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [6:0]           char_out_o;
  logic                 last_char_o;

  binary_to_hex_record_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o)
  );

  // encoder state mirrored by the predictor
  logic [1:0]  enc_fmt     = CFG_FMT_SREC;
  logic [7:0]  enc_size    = REC_SIZE_RST;
  logic [23:0] enc_img_len = '0;
  logic [23:0] enc_offset  = '0;
  logic [23:0] enc_addr    = '0;
  logic [7:0]  enc_pos     = '0;
  logic [7:0]  enc_rec_len = '0;
  logic [7:0]  enc_sum     = '0;

  logic [7:0] item_chars_q[$];
  char_res_t  chars_due_q[$];
  dir_row_t   dir_rows[$];
  string      dir_text[$];

  int fail_count    = 0;
  int counted_items = 0;
  int chars_seen    = 0;
  int next_hold     = 300;
  int stall_left    = 0;
  int out_style     = 1;
  int style_left    = 0;
  int quiet_cycles  = 0;

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic rec_fmt_e fmt_kind();
    rec_fmt_e f;
    case (enc_fmt)
      CFG_FMT_IHEX: f = FMT_IHEX;
      CFG_FMT_TEK:  f = FMT_TEK;
      default:      f = FMT_SREC;
    endcase
    return f;
  endfunction

  // an item yields at most MAX_CHARS chars, the rest is cut off
  function automatic void emit_char(logic [7:0] c);
    if (item_chars_q.size() < MAX_CHARS) item_chars_q.push_back(c);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? ("0" + 8'(n)) : ("A" + 8'(n) - 8'd10);
  endfunction

  // two hex digits; tekhex sums nibbles, the others sum bytes
  function automatic void emit_pair(logic [7:0] v);
    emit_char(hex_char(v[7:4]));
    emit_char(hex_char(v[3:0]));
    if (fmt_kind() == FMT_TEK) enc_sum = enc_sum + v[7:4] + v[3:0];
    else enc_sum = enc_sum + v;
  endfunction

  function automatic void emit_text(string t);
    int k;
    for (k = 0; k < t.len(); k++) emit_char(t[k]);
  endfunction

  function automatic void close_rec();
    logic [7:0] s;
    s = enc_sum;
    case (fmt_kind())
      FMT_TEK:  emit_pair(s);
      FMT_IHEX: emit_pair(~s + 8'd1);
      default:  emit_pair(~s);
    endcase
    emit_char("\n");
    enc_pos = '0;
  endfunction

  // chars caused by one input word go to item_chars_q
  function automatic void encode_item(logic op, logic [7:0] d);
    logic [7:0]  rs;
    logic [7:0]  rlen;
    logic [23:0] remain;
    logic [23:0] a;
    item_chars_q.delete();
    if (op == OP_FINISH) begin
      if (enc_pos != 0) close_rec();
      case (fmt_kind())
        FMT_TEK:  emit_text("/00000000\n");
        FMT_IHEX: emit_text(":00000001FF\n");
        default: begin
          enc_sum = '0;
          emit_char("S");
          emit_char("8");
          emit_pair(8'h04);
          emit_pair(enc_offset[23:16]);
          emit_pair(enc_offset[15:8]);
          emit_pair(enc_offset[7:0]);
          emit_pair(~enc_sum);
          emit_char("\n");
        end
      endcase
      enc_addr    = '0;
      enc_pos     = '0;
      enc_rec_len = '0;
      enc_sum     = '0;
    end else if (enc_addr < enc_img_len) begin
      // header of a new record
      if (enc_pos == 0) begin
        rs = (enc_size == 0) ? 8'd1 : enc_size;
        if (fmt_kind() == FMT_SREC && rs > SREC_MAX_SIZE) rs = SREC_MAX_SIZE;
        remain = enc_img_len - enc_addr;
        rlen = (remain < {16'd0, rs}) ? remain[7:0] : rs;
        enc_rec_len = rlen;
        enc_sum = '0;
        case (fmt_kind())
          FMT_TEK: begin
            emit_char("/");
            emit_pair(enc_addr[15:8]);
            emit_pair(enc_addr[7:0]);
            emit_pair(rlen);
            emit_pair(enc_sum);
            enc_sum = '0;
          end
          FMT_IHEX: begin
            emit_char(":");
            emit_pair(rlen);
            emit_pair(enc_addr[15:8]);
            emit_pair(enc_addr[7:0]);
            emit_pair(8'h00);
          end
          default: begin
            a = enc_addr + enc_offset;
            emit_char("S");
            emit_char("2");
            emit_pair(rlen + 8'd4);
            emit_pair(a[23:16]);
            emit_pair(a[15:8]);
            emit_pair(a[7:0]);
          end
        endcase
      end
      emit_pair(d);
      enc_pos  = enc_pos + 8'd1;
      enc_addr = enc_addr + 24'd1;
      if (enc_pos >= enc_rec_len) close_rec();
    end
  endfunction

  // ---------------------------------------------------------------- driving

  // mostly no gap, some short ones and a few long ones
  function automatic int pick_idle(int style);
    int r;
    r = $urandom_range(0, 99);
    if (style == 0 || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // let the block drain before touching its registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (chars_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val, input bit more);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_FORMAT: enc_fmt     = val[1:0];
      CFG_SIZE:   enc_size    = val[7:0];
      CFG_LENGTH: enc_img_len = val;
      CFG_OFFSET: enc_offset  = val;
      default: begin
      end
    endcase
    if (!more) cfg_we_i <= 1'b0;
  endtask

  // offer one word, predict its chars once taken, then maybe idle
  task automatic send_item(input logic op, input logic [7:0] d, input bit typed,
                           input string text, input int style);
    int gap;
    int k;
    opcode_i    <= op;
    data_byte_i <= d;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_item(op, d);
    if (typed) begin
      item_chars_q.delete();
      emit_text(text);
    end
    if (item_chars_q.size() != 0) counted_items++;
    for (k = 0; k < item_chars_q.size(); k++)
      chars_due_q.push_back({item_chars_q[k][6:0], k == item_chars_q.size() - 1});
    gap = pick_idle(style);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic void add_cfg(logic [1:0] idx, logic [23:0] val);
    dir_rows.push_back({1'b1, idx, val, OP_DATA, 8'd0, 1'b0});
    dir_text.push_back("");
  endfunction

  function automatic void add_item(logic op, logic [7:0] d);
    dir_rows.push_back({1'b0, 2'd0, 24'd0, op, d, 1'b0});
    dir_text.push_back("");
  endfunction

  function automatic void add_typed(logic op, logic [7:0] d, string t);
    dir_rows.push_back({1'b0, 2'd0, 24'd0, op, d, 1'b1});
    dir_text.push_back(t);
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    int          i;
    int          n_bytes;
    int          style;
    int          r;
    logic [1:0]  fmt_code;
    logic [7:0]  sz;
    logic [7:0]  d;
    logic [23:0] len_v;
    logic [23:0] off_v;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_FORMAT;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    opcode_i    <= OP_DATA;
    data_byte_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: s-record, empty image
    add_typed(OP_FINISH, 8'h00, "S804000000FB\n");
    add_typed(OP_DATA, 8'h00, "");
    // two-byte records, offset wraps the address
    add_cfg(CFG_LENGTH, 24'd5);
    add_cfg(CFG_SIZE, 24'd2);
    add_cfg(CFG_OFFSET, 24'hFFFFFF);
    add_item(OP_DATA, 8'hFF);
    add_item(OP_DATA, 8'h00);
    add_item(OP_DATA, 8'h80);
    add_item(OP_FINISH, 8'hFF);
    // intel, size above the image, bytes past the end ignored
    add_cfg(CFG_FORMAT, {22'd0, CFG_FMT_IHEX});
    add_cfg(CFG_SIZE, 24'd255);
    add_cfg(CFG_LENGTH, 24'd3);
    add_item(OP_DATA, 8'h12);
    add_item(OP_DATA, 8'hAB);
    add_item(OP_DATA, 8'hFF);
    add_typed(OP_DATA, 8'h55, "");
    add_typed(OP_FINISH, 8'h00, ":00000001FF\n");
    // tekhex with size zero, taken as one
    add_cfg(CFG_FORMAT, {22'd0, CFG_FMT_TEK});
    add_cfg(CFG_SIZE, 24'd0);
    add_cfg(CFG_LENGTH, 24'hFFFFFF);
    add_item(OP_DATA, 8'hA5);
    add_item(OP_DATA, 8'h5A);
    add_typed(OP_FINISH, 8'h00, "/00000000\n");
    // spare format code, finish with a record open
    add_cfg(CFG_FORMAT, {22'd0, FMT_CODE_SPARE});
    add_cfg(CFG_SIZE, 24'd255);
    add_cfg(CFG_OFFSET, 24'h123456);
    add_cfg(CFG_LENGTH, 24'd2);
    add_item(OP_DATA, 8'h01);
    add_item(OP_FINISH, 8'h00);
    // format and size changed inside an open record
    add_cfg(CFG_FORMAT, {22'd0, CFG_FMT_SREC});
    add_cfg(CFG_SIZE, 24'd4);
    add_cfg(CFG_LENGTH, 24'd10);
    add_cfg(CFG_OFFSET, 24'd0);
    add_item(OP_DATA, 8'h10);
    add_cfg(CFG_FORMAT, {22'd0, CFG_FMT_IHEX});
    add_item(OP_DATA, 8'h20);
    add_cfg(CFG_SIZE, 24'd1);
    add_item(OP_DATA, 8'h30);
    add_item(OP_DATA, 8'h40);
    add_item(OP_FINISH, 8'h00);

    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_cfg) begin
        if (i == 0 || !dir_rows[i-1].is_cfg) wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].val,
                  i + 1 < dir_rows.size() && dir_rows[i+1].is_cfg);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].data_v, dir_rows[i].typed, dir_text[i], 1);
      end
    end

    // random images, one per phase
    counted_items = 0;
    while (counted_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      fmt_code = (r < 5) ? FMT_CODE_SPARE : 2'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (r < 60)      sz = 8'($urandom_range(1, 8));
      else if (r < 75) sz = 8'($urandom_range(9, 40));
      else if (r < 80) sz = 8'd0;
      else if (r < 85) sz = 8'd255;
      else if (r < 90) sz = SREC_MAX_SIZE;
      else if (r < 93) sz = 8'd252;
      else             sz = 8'($urandom_range(1, 255));
      r = $urandom_range(0, 99);
      if (r < 85)      n_bytes = $urandom_range(1, 24);
      else if (r < 97) n_bytes = $urandom_range(25, 64);
      else             n_bytes = $urandom_range(252, 280);
      r = $urandom_range(0, 99);
      if (r < 75)      len_v = 24'(n_bytes);
      else if (r < 88) len_v = 24'($urandom_range(0, n_bytes));
      else if (r < 94) len_v = 24'hFFFFFF;
      else             len_v = 24'($urandom);
      off_v = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(24'hFFFFF0, 24'hFFFFFF))
                                          : 24'($urandom);
      style = ($urandom_range(0, 3) == 0) ? 0 : 1;

      wait_idle();
      write_reg(CFG_FORMAT, {22'($urandom), fmt_code}, 1'b1);
      write_reg(CFG_SIZE, {16'($urandom), sz}, 1'b1);
      write_reg(CFG_LENGTH, len_v, 1'b1);
      write_reg(CFG_OFFSET, off_v, 1'b0);

      for (i = 0; i < n_bytes; i++) begin
        // a stray finish breaks the image now and then
        if ($urandom_range(0, 99) < 3) send_item(OP_FINISH, 8'($urandom), 1'b0, "", style);
        r = $urandom_range(0, 99);
        d = (r < 5) ? 8'h00 : (r < 10) ? 8'hFF : 8'($urandom);
        send_item(OP_DATA, d, 1'b0, "", style);
      end
      if ($urandom_range(0, 9) != 0) send_item(OP_FINISH, 8'($urandom), 1'b0, "", style);
    end

    // drain and report
    wait_idle();
    if (fail_count == 0 && chars_due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiving

  // check each char taken, then choose the stall for the next cycle
  always @(posedge clk_i) begin
    char_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        chars_seen++;
        if (chars_due_q.size() == 0) begin
          $display("%0t: unexpected char, expected none, actual %h last %b",
                   $time, char_out_o, last_char_o);
          fail_count++;
        end else begin
          want = chars_due_q.pop_front();
          if (char_out_o !== want.ch) begin
            $display("%0t: char_out mismatch, expected %h, actual %h",
                     $time, want.ch, char_out_o);
            fail_count++;
          end
          if (last_char_o !== want.last) begin
            $display("%0t: last_char mismatch, expected %b, actual %b",
                     $time, want.last, last_char_o);
            fail_count++;
          end
        end
      end

      // stretches of free flow alternate with stretches of random stalls
      if (style_left == 0) begin
        out_style  = $urandom_range(0, 1);
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end

      // long hold-off so the block fills and stalls its input
      if (stall_left > 0) begin
        stall_left--;
      end else if (chars_seen >= next_hold) begin
        stall_left = HOLD_CYCLES;
        next_hold  = next_hold + 400;
      end else begin
        stall_left = pick_idle(out_style);
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

[files.f]
src/b2h_pkg.sv
src/b2h_front.sv
src/b2h_queue.sv
src/b2h_back.sv
src/binary_to_hex_record_encoder_core.sv
dv/tb_binary_to_hex_record_encoder_core.sv
